@@ src/sawbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbc_pkg: shared types and constants for the set-associative cache
// Controller states, the command and status groups between controller and
// datapath, and the fixed widths of the access and result fields.
// ----------------------------------------------------------------------------
package sawbc_pkg;

	localparam int ADDR_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int OUT_LINE_W = 64;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic look;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
	} ctl_status_t;

endpackage

@@ src/sawbc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered and held until the
// next read.
// ----------------------------------------------------------------------------
module sawbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/sawbc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbc_ctrl: access sequencer
// Runs the clearing sweep after reset, then steps each access through
// lookup and decide.
// ----------------------------------------------------------------------------
module sawbc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  sawbc_pkg::ctl_status_t status,
	output sawbc_pkg::ctl_cmd_t    cmd,
	output logic                   busy
);
	import sawbc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ src/sawbc_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbc_dpath: cache datapath
// Set row RAM, backing line RAM, age stage, hit and victim selection, row
// update, write-back and result registers.
// ----------------------------------------------------------------------------
module sawbc_dpath #(
	parameter int WAYS        = 4,
	parameter int SET_BITS    = 4,
	parameter int OFFSET_BITS = 3,
	parameter int AGE_BITS    = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sawbc_pkg::ctl_cmd_t    cmd,
	output sawbc_pkg::ctl_status_t status,
	input  logic                   op,
	input  logic [15:0]            address,
	input  logic [7:0]             write_byte,
	output logic [15:0]            read_address,
	output logic [63:0]            line_bytes,
	output logic                   was_hit,
	output logic                   was_dirty,
	output logic                   result_strobe
);
	import sawbc_pkg::*;

	localparam int SETS      = 1 << SET_BITS;
	localparam int TAG_W     = ADDR_W - SET_BITS - OFFSET_BITS;
	localparam int LINE_W    = BYTE_W << OFFSET_BITS;
	localparam int MEM_AW    = ADDR_W - OFFSET_BITS;
	localparam int MEM_LINES = 1 << MEM_AW;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TREE_N    = 1 << $clog2(WAYS);
	localparam int OFF_W     = (OFFSET_BITS > 0) ? OFFSET_BITS : 1;
	localparam int ENTRY_W   = LINE_W + AGE_BITS + TAG_W + 1;
	localparam int ROW_W     = WAYS * ENTRY_W;
	localparam int AGE_OFS   = LINE_W;
	localparam int TAG_OFS   = LINE_W + AGE_BITS;
	localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

	// request
	logic                op_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [BYTE_W-1:0]   wbyte_q;
	logic [MEM_AW-1:0]   clr_q;

	logic [SET_BITS-1:0] set_idx;
	logic [TAG_W-1:0]    tag_in;
	logic [OFF_W-1:0]    offset;

	// RAM ports
	logic [ROW_W-1:0]    row_rdata;
	logic [ROW_W-1:0]    row_wdata;
	logic [ROW_W-1:0]    new_row;
	logic                row_we;
	logic [SET_BITS-1:0] row_waddr;
	logic [LINE_W-1:0]   mem_rdata;
	logic [LINE_W-1:0]   mem_wdata;
	logic                mem_we;
	logic [MEM_AW-1:0]   mem_waddr;

	// unpacked row
	logic [LINE_W-1:0]   o_data  [WAYS];
	logic [AGE_BITS-1:0] o_age   [WAYS];
	logic [TAG_W-1:0]    o_tag   [WAYS];
	logic                o_dirty [WAYS];
	logic [LINE_W-1:0]   n_data  [WAYS];
	logic [AGE_BITS-1:0] n_age   [WAYS];
	logic [TAG_W-1:0]    n_tag   [WAYS];
	logic                n_dirty [WAYS];

	// lookup stage
	logic [AGE_BITS-1:0] age_s1 [WAYS];
	logic                hit_s1;
	logic [WAY_W-1:0]    hit_way_s1;
	logic                hit_c;
	logic [WAY_W-1:0]    hit_way_c;

	// victim tree, heap order
	logic [AGE_BITS-1:0] tv [2*TREE_N];
	logic [WAY_W-1:0]    ti [2*TREE_N];
	logic [WAY_W-1:0]    chosen;
	logic                wb_needed;
	logic [MEM_AW-1:0]   wb_addr;

	// results
	logic [ADDR_W-1:0]     read_address_q;
	logic [OUT_LINE_W-1:0] line_q;
	logic                  hit_q;
	logic                  dirty_q;
	logic                  strobe_q;

	assign set_idx = addr_q[OFFSET_BITS +: SET_BITS];
	assign tag_in  = addr_q[ADDR_W-1 -: TAG_W];

	generate
		if (OFFSET_BITS > 0) begin : g_off
			assign offset = addr_q[OFF_W-1:0];
		end else begin : g_no_off
			assign offset = '0;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= op;
			addr_q  <= address;
			wbyte_q <= write_byte;
		end
	end

	// clearing sweep over every memory line; the set rows ride along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + MEM_AW'(1);
		end
	end

	assign status.clr_last = (clr_q == {MEM_AW{1'b1}});

	sawbc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (cmd.accept),
		.raddr (address[OFFSET_BITS +: SET_BITS]),
		.rdata (row_rdata)
	);

	sawbc_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MEM_LINES)
	) u_mem_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.accept),
		.raddr (address[ADDR_W-1 -: MEM_AW]),
		.rdata (mem_rdata)
	);

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			o_data[w]  = row_rdata[w*ENTRY_W +: LINE_W];
			o_age[w]   = row_rdata[w*ENTRY_W + AGE_OFS +: AGE_BITS];
			o_tag[w]   = row_rdata[w*ENTRY_W + TAG_OFS +: TAG_W];
			o_dirty[w] = row_rdata[w*ENTRY_W + ENTRY_W - 1];
		end
	end

	// lowest matching way wins
	always_comb begin
		hit_c     = 1'b0;
		hit_way_c = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (o_tag[w] == tag_in) begin
				hit_c     = 1'b1;
				hit_way_c = WAY_W'(w);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			for (int w = 0; w < WAYS; w++) begin
				age_s1[w] <= (o_age[w] == AGE_MAX) ? o_age[w] : o_age[w] + AGE_BITS'(1);
			end
			hit_s1     <= hit_c;
			hit_way_s1 <= hit_way_c;
		end
	end

	// oldest way, ties to the higher index; padding leaves hold age zero,
	// which never beats an aged way
	always_comb begin
		for (int i = 0; i < TREE_N; i++) begin
			if (i < WAYS) begin
				tv[TREE_N + i] = age_s1[i];
			end else begin
				tv[TREE_N + i] = '0;
			end
			ti[TREE_N + i] = WAY_W'(i);
		end
		tv[0] = '0;
		ti[0] = '0;
		for (int n = TREE_N - 1; n >= 1; n--) begin
			if (tv[2*n + 1] >= tv[2*n]) begin
				tv[n] = tv[2*n + 1];
				ti[n] = ti[2*n + 1];
			end else begin
				tv[n] = tv[2*n];
				ti[n] = ti[2*n];
			end
		end
	end

	always_comb begin
		chosen    = hit_s1 ? hit_way_s1 : ti[1];
		wb_needed = !hit_s1 && o_dirty[chosen];
		wb_addr   = {o_tag[chosen], set_idx};
		for (int w = 0; w < WAYS; w++) begin
			n_data[w]  = o_data[w];
			n_age[w]   = age_s1[w];
			n_tag[w]   = o_tag[w];
			n_dirty[w] = o_dirty[w];
		end
		n_age[chosen] = '0;
		if (!hit_s1) begin
			n_tag[chosen]   = tag_in;
			n_data[chosen]  = mem_rdata;
			n_dirty[chosen] = 1'b0;
		end
		if (op_q == OP_WRITE) begin
			n_data[chosen][{offset, 3'b000} +: BYTE_W] = wbyte_q;
			n_dirty[chosen] = 1'b1;
		end
		for (int w = 0; w < WAYS; w++) begin
			new_row[w*ENTRY_W +: ENTRY_W] = {n_dirty[w], n_tag[w], n_age[w], n_data[w]};
		end
	end

	always_comb begin
		row_we    = cmd.clear || cmd.commit;
		row_waddr = cmd.clear ? clr_q[SET_BITS-1:0] : set_idx;
		row_wdata = cmd.clear ? '0 : new_row;
		mem_we    = cmd.clear || (cmd.commit && wb_needed);
		mem_waddr = cmd.clear ? clr_q : wb_addr;
		mem_wdata = cmd.clear ? '0 : o_data[chosen];
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			read_address_q <= addr_q;
			line_q         <= OUT_LINE_W'(n_data[chosen]);
			hit_q          <= hit_s1;
			dirty_q        <= o_dirty[chosen];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.commit && (op_q == OP_READ);
		end
	end

	assign read_address  = read_address_q;
	assign line_bytes    = line_q;
	assign was_hit       = hit_q;
	assign was_dirty     = dirty_q;
	assign result_strobe = strobe_q;

endmodule

@@ src/set_assoc_writeback_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache: set-associative write-back cache with LRU ages
// Byte reads and writes to a 16-bit address space, served by a WAYS-way
// cache of 2^SET_BITS sets in front of a cleared backing memory.
// ----------------------------------------------------------------------------
// Every access, hit or miss, goes through the same steps: the accept cycle reads the set
// row and the refill line at once, the lookup cycle ages the ways and finds
// the hit, and the decide cycle picks the victim, writes back a dirty line
// and writes the updated row. busy is high from the accept edge until the
// decide cycle ends, so a new start is only taken once the previous access
// is done. A read returns its beat on read_address, line_bytes, was_hit
// and was_dirty for exactly one cycle, flagged by result_strobe, in the
// cycle after the decide edge; the receiver cannot stall it, so capture it
// then. Writes return nothing. After reset the block sweeps the backing
// memory and the set rows to zero, one memory line a cycle, over all
// 2^(16-OFFSET_BITS) memory lines, with busy high throughout.
// ----------------------------------------------------------------------------
module set_assoc_writeback_cache #(
	parameter int WAYS        = 4,
	parameter int SET_BITS    = 4,
	parameter int OFFSET_BITS = 3,
	parameter int AGE_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [15:0] address,
	input  logic [7:0]  write_byte,
	output logic        result_strobe,
	output logic [15:0] read_address,
	output logic [63:0] line_bytes,
	output logic        was_hit,
	output logic        was_dirty
);
	import sawbc_pkg::*;

	ctl_cmd_t    cmd;
	ctl_status_t status;

	// sequence: clear sweep, then accept, lookup, decide per access
	sawbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// storage, selection and result registers
	sawbc_dpath #(
		.WAYS        (WAYS),
		.SET_BITS    (SET_BITS),
		.OFFSET_BITS (OFFSET_BITS),
		.AGE_BITS    (AGE_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.op            (op),
		.address       (address),
		.write_byte    (write_byte),
		.read_address  (read_address),
		.line_bytes    (line_bytes),
		.was_hit       (was_hit),
		.was_dirty     (was_dirty),
		.result_strobe (result_strobe)
	);

endmodule

@@ src/sawbc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sawbc_checker: port-level timing checks for the cache
// Watches accepts and result beats on the top level's ports.
// ----------------------------------------------------------------------------
module sawbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        op,
	input logic [15:0] address,
	input logic        result_strobe,
	input logic [15:0] read_address
);
	import sawbc_pkg::*;

	logic accept;
	assign accept = start && !busy;

	// a read accept is followed by its result beat, after the lookup and decide states
	a_read_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == OP_READ) |-> ##3 result_strobe)
		else $error("read accept without result beat three cycles later");

	// a write produces no beat
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == OP_WRITE) |-> ##3 !result_strobe)
		else $error("write accept produced a result beat");

	// every beat traces back to an accept, with its address echoed
	a_beat_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(accept, 3) && (read_address == $past(address, 3)))
		else $error("result beat without matching accept or address");

	// busy holds off a second start right after an accept
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy low right after accept");

	// beats never fall in adjacent cycles
	a_beat_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("result beats in adjacent cycles");

endmodule

bind set_assoc_writeback_cache sawbc_checker u_checker (.*);
